### rtl/core/fgr_pkg.sv
// Shared types, constants and transform codes for the frame remap block.
package fgr_pkg;

	// Source store is never larger than this many pixels on a side.
	localparam int STORE_DIM    = 256;
	localparam int DEFAULT_SIDE = 256;
	localparam int QDEPTH       = 2;

	localparam logic [7:0] WHITE = 8'hFF;

	localparam logic [3:0] TR_SHRINK2  = 4'd0;
	localparam logic [3:0] TR_SHRINK3  = 4'd1;
	localparam logic [3:0] TR_SHRINK4  = 4'd2;
	localparam logic [3:0] TR_MIR_LEFT = 4'd3;
	localparam logic [3:0] TR_MIR_RGHT = 4'd4;
	localparam logic [3:0] TR_MIR_TOP  = 4'd5;
	localparam logic [3:0] TR_MIR_BOT  = 4'd6;
	localparam logic [3:0] TR_FLIP_ROW = 4'd7;
	localparam logic [3:0] TR_FLIP_COL = 4'd8;
	localparam logic [3:0] TR_ENL_TL   = 4'd9;
	localparam logic [3:0] TR_ENL_TR   = 4'd10;
	localparam logic [3:0] TR_ENL_BL   = 4'd11;
	localparam logic [3:0] TR_ENL_BR   = 4'd12;

	// One classified operation waiting for the store.
	typedef struct packed {
		logic       rd;
		logic       white;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] data;
	} fgr_entry_t;

endpackage

### rtl/core/fgr_front.sv
// Front end: accept items, map read coordinates to source locations, classify.
module fgr_front #(
	parameter int SIDE = fgr_pkg::DEFAULT_SIDE
) (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [7:0]          row,
	input  logic [7:0]          col,
	input  logic [7:0]          pixel_in,
	input  logic [3:0]          transform,
	input  logic                q_full,
	output logic                q_push,
	output fgr_pkg::fgr_entry_t q_entry
);
	import fgr_pkg::*;

	localparam int LIM = (SIDE < STORE_DIM) ? SIDE : STORE_DIM;
	localparam int GW  = ($clog2(SIDE) + 1 > 10) ? $clog2(SIDE) + 1 : 10;
	localparam logic [GW-1:0] LAST = GW'(SIDE - 1);
	localparam logic [GW-1:0] HALF = GW'(SIDE / 2);

	logic [GW-1:0] r_g, c_g, sr, sc;
	logic          outside, white;

	assign r_g     = GW'(row);
	assign c_g     = GW'(col);
	assign outside = (r_g >= GW'(SIDE)) || (c_g >= GW'(SIDE));

	always_comb begin
		sr = r_g;
		sc = c_g;
		unique case (transform) inside
			TR_SHRINK2: begin
				sr = r_g << 1;
				sc = c_g << 1;
			end
			TR_SHRINK3: begin
				sr = (r_g << 1) + r_g;
				sc = (c_g << 1) + c_g;
			end
			TR_SHRINK4: begin
				sr = r_g << 2;
				sc = c_g << 2;
			end
			TR_MIR_LEFT: sc = (c_g <  HALF) ? c_g : LAST - c_g;
			TR_MIR_RGHT: sc = (c_g >= HALF) ? c_g : LAST - c_g;
			TR_MIR_TOP:  sr = (r_g <  HALF) ? r_g : LAST - r_g;
			TR_MIR_BOT:  sr = (r_g >= HALF) ? r_g : LAST - r_g;
			TR_FLIP_ROW: sr = LAST - r_g;
			TR_FLIP_COL: sc = LAST - c_g;
			TR_ENL_TL, TR_ENL_TR, TR_ENL_BL, TR_ENL_BR: begin
				sr = (r_g >> 1) + ((transform == TR_ENL_BL || transform == TR_ENL_BR)
					? HALF : '0);
				sc = (c_g >> 1) + ((transform == TR_ENL_TR || transform == TR_ENL_BR)
					? HALF : '0);
			end
			default: begin
				sr = r_g;
				sc = c_g;
			end
		endcase
	end

	// Any source past the stored frame reads as white; shrink overflow lands here too.
	assign white = outside || (sr >= GW'(LIM)) || (sc >= GW'(LIM));

	assign in_ready = !q_full;
	// Drop writes outside the frame: accepted, never queued.
	assign q_push   = in_valid && !q_full && !(!func && outside);

	always_comb begin
		q_entry.rd    = func;
		q_entry.white = func && white;
		q_entry.row   = func ? sr[7:0] : row;
		q_entry.col   = func ? sc[7:0] : col;
		q_entry.data  = pixel_in;
	end

endmodule

### rtl/core/fgr_queue.sv
// Short FIFO between the front end and the store back end.
module fgr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fgr_pkg::fgr_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output fgr_pkg::fgr_entry_t head
);
	import fgr_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	fgr_entry_t        slots_q [QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full  = (count_q == CW'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
`endif

endmodule

### rtl/core/fgr_back.sv
// Back end: frame store access and the registered result slot.
module fgr_back #(
	parameter int SIDE = fgr_pkg::DEFAULT_SIDE
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  fgr_pkg::fgr_entry_t q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          pixel_out
);
	import fgr_pkg::*;

	localparam int LIM = (SIDE < STORE_DIM) ? SIDE : STORE_DIM;
	localparam int AW  = $clog2(LIM);

	logic [7:0]      store_q [2**(2*AW)];
	logic [2*AW-1:0] addr;
	logic [7:0]      rd_s1;
	logic            pend_s1, white_s1;
	logic            out_valid_q;
	logic [7:0]      pix_q;
	logic            slot_free;

	assign addr      = {q_head.row[AW-1:0], q_head.col[AW-1:0]};
	// A read may issue only when the result slot will be free for its data as it leaves the store read register.
	assign slot_free = !pend_s1 && (!out_valid_q || out_ready);
	assign q_pop     = !q_empty && (!q_head.rd || slot_free);

	always_ff @(posedge clk) begin
		if (q_pop && !q_head.rd) begin
			store_q[addr] <= q_head.data;
		end
		if (q_pop && q_head.rd) begin
			rd_s1 <= store_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= q_pop && q_head.rd;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			white_s1 <= q_head.white;
		end
		if (pend_s1) begin
			pix_q <= white_s1 ? WHITE : rd_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_q;

`ifndef SYNTHESIS
	a_slot_free_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q) else $error("read data would overwrite result");
	a_white_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && white_s1) |=> (out_valid && pixel_out == WHITE))
		else $error("white source did not give white result");
`endif

endmodule

### rtl/core/frame_geometric_remap.sv
// Top level of the nearest-neighbor frame remap block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  input    | in_valid / in_ready    | func, row, col, pixel_in
//  output   | out_valid / out_ready  | pixel_out
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// A write lands in the store once it is at the queue head; a read goes on through the store
// read register into the result slot behind out_valid. A read waits while the last read is
// in the store read register or the single result slot is stalled; writes issue every
// cycle unless held behind a read. The two-entry queue keeps the front accepting. Reset
// clears control state and the transform register only; the frame store holds whatever it
// held. A stalled output holds the read at the queue head and everything queued behind it.
module frame_geometric_remap #(
	parameter int SIDE = fgr_pkg::DEFAULT_SIDE
) (
	input  logic        clk,
	input  logic        arst_n,
	// input transaction channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  row,
	input  logic [7:0]  col,
	input  logic [7:0]  pixel_in,
	// output transaction channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel_out,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fgr_pkg::*;

	logic       [3:0] transform_q;
	logic             q_push, q_pop, q_full, q_empty;
	fgr_entry_t       q_in, q_head;

	// Only one register, at byte address 0; upper address bit selects nothing else.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {28'd0, transform_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transform_q <= TR_SHRINK2;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			transform_q <= pwdata[3:0];
		end
	end

	// Front: accept, map coordinates, classify into store operations.
	fgr_front #(.SIDE(SIDE)) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.row       (row),
		.col       (col),
		.pixel_in  (pixel_in),
		.transform (transform_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	// Queue: decouple classification from store access.
	fgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	// Back: carry out writes and reads on the frame store, hold the result.
	fgr_back #(.SIDE(SIDE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out)
	);

endmodule

### verif/frame_geometric_remap_tb.sv
// Self-checking testbench for the frame_geometric_remap nearest-neighbor remap block.
`timescale 1ns / 1ps

module frame_geometric_remap_tb;
	import fgr_pkg::*;

	localparam int SIDE        = fgr_pkg::DEFAULT_SIDE;
	localparam int RAND_ITEMS  = 1950;
	localparam int SETTLE_CYC  = 8;     // covers the deepest read path plus queue
	localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
	localparam int MAX_SHOWN   = 10;

	localparam logic       FUNC_WR        = 1'b0;
	localparam logic       FUNC_RD        = 1'b1;
	localparam logic [2:0] TRANSFORM_ADDR = 3'd0;

	// Directed script entries: source pixel load, output pixel read, transform change.
	typedef enum logic [1:0] {ST_WR, ST_RD, ST_CFG} script_kind_t;

	typedef struct {
		script_kind_t kind;
		logic [7:0]   r;
		logic [7:0]   c;
		logic [7:0]   v;   // pixel on a load, expected pixel on a read, code on a change
	} script_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = FUNC_WR;
	logic [7:0]  row = 8'd0;
	logic [7:0]  col = 8'd0;
	logic [7:0]  pixel_in = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  pixel_out;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow of the source frame and of the transform register.
	logic [7:0]  frame_img [0:STORE_DIM*STORE_DIM-1];
	bit          loaded    [0:STORE_DIM*STORE_DIM-1];
	logic [3:0]  cur_xf = TR_SHRINK2;

	logic [7:0]  pixel_q [$];   // expected output pixels, oldest first
	script_step_t script_q [$];

	int err_cnt = 0;
	int n_items = 0;
	int n_results = 0;
	int n_xf_writes = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int idle_cycles = 0;

	frame_geometric_remap #(.SIDE(SIDE)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .row(row), .col(col), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_ready(out_ready), .pixel_out(pixel_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int exp_v, input int act_v);
		err_cnt++;
		if (err_cnt <= MAX_SHOWN)
			$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
	endtask

	// Work out which source pixel feeds output (r, c) under transform xf.
	// The return value is white whenever no store entry is touched.
	function automatic logic [7:0] remap_pixel(input logic [3:0] xf, input int r, input int c,
			output bit hits_store, output int src_addr);
		int last;
		int half;
		int k;
		int sr;
		int sc;
		bit white;
		last = SIDE - 1;
		half = SIDE / 2;
		sr = r;
		sc = c;
		white = 1'b0;
		case (xf)
			TR_SHRINK2, TR_SHRINK3, TR_SHRINK4: begin
				k = int'(xf) + 2;
				sr = r * k;
				sc = c * k;
				if (sr > last || sc > last)
					white = 1'b1;
			end
			TR_MIR_LEFT: if (c >= half) sc = last - c;
			TR_MIR_RGHT: if (c < half) sc = last - c;
			TR_MIR_TOP:  if (r >= half) sr = last - r;
			TR_MIR_BOT:  if (r < half) sr = last - r;
			TR_FLIP_ROW: sr = last - r;
			TR_FLIP_COL: sc = last - c;
			TR_ENL_TL, TR_ENL_TR, TR_ENL_BL, TR_ENL_BR: begin
				sr = r / 2 + ((xf == TR_ENL_BL || xf == TR_ENL_BR) ? half : 0);
				sc = c / 2 + ((xf == TR_ENL_TR || xf == TR_ENL_BR) ? half : 0);
			end
			default: ;  // unused codes pass the pixel straight through
		endcase
		if (r >= SIDE || c >= SIDE || sr >= SIDE || sc >= SIDE ||
				sr >= STORE_DIM || sc >= STORE_DIM)
			white = 1'b1;
		hits_store = !white;
		src_addr = sr * STORE_DIM + sc;
		return white ? WHITE : frame_img[src_addr];
	endfunction

	// After an optional random idle gap, present one pixel transaction and hold it until accepted.
	// Valid stays high on return so back-to-back transactions need no extra edge.
	task automatic push_pixel_op(input logic f, input int r, input int c, input int px,
			input bit typed, input logic [7:0] typed_px);
		int gap;
		int sa;
		bit hits;
		bit took;
		logic [7:0] predicted;
		gap = 0;
		while (gap < 12 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		row      <= 8'(r);
		col      <= 8'(c);
		pixel_in <= 8'(px);
		// sample ready mid-cycle, where nothing is changing
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		n_items++;
		if (f == FUNC_WR) begin
			if (r < SIDE && c < SIDE) begin
				frame_img[r * STORE_DIM + c] = 8'(px);
				loaded[r * STORE_DIM + c] = 1'b1;
			end
		end else begin
			predicted = remap_pixel(cur_xf, r, c, hits, sa);
			pixel_q.push_back(typed ? typed_px : predicted);
		end
	endtask

	// Drop valid and let every outstanding read drain before touching the register.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write the transform register with a setup and an access phase, then read it back.
	task automatic write_transform(input logic [3:0] xf);
		bit done;
		logic [31:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TRANSFORM_ADDR;
		pwdata  <= {28'd0, xf};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		cur_xf = xf;
		n_xf_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			rd = prdata;
			@(posedge clk);
		end while (!done);
		if (rd !== {28'd0, xf})
			report_mismatch("transform readback", int'(xf), int'(rd));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void script(input script_kind_t kind, input logic [7:0] r,
			input logic [7:0] c, input logic [7:0] v);
		script_step_t s;
		s.kind = kind;
		s.r = r;
		s.c = c;
		s.v = v;
		script_q.push_back(s);
	endfunction

	// Favor the frame edges, the half boundary and the shrink limits, where the mappings turn over.
	function automatic int pick_coord();
		int corner_pts [13] = '{0, 1, 63, 64, 84, 85, 86, 126, 127, 128, 129, 254, 255};
		if ($urandom_range(99) < 25)
			return corner_pts[$urandom_range(12)];
		return $urandom_range(255);
	endfunction

	// One random step: a stray load, or a read whose source pixel is loaded first
	// if it never was (and sometimes reloaded, to hit the write-then-read path).
	task automatic random_step();
		int r;
		int c;
		int sa;
		bit hits;
		logic [7:0] ignored;
		if ($urandom_range(99) < 35) begin
			push_pixel_op(FUNC_WR, $urandom_range(255), $urandom_range(255),
				$urandom_range(255), 1'b0, 8'd0);
		end else begin
			r = pick_coord();
			c = pick_coord();
			ignored = remap_pixel(cur_xf, r, c, hits, sa);
			if (hits && (!loaded[sa] || $urandom_range(99) < 20))
				push_pixel_op(FUNC_WR, sa / STORE_DIM, sa % STORE_DIM, $urandom_range(255),
					1'b0, 8'd0);
			push_pixel_op(FUNC_RD, r, c, $urandom_range(255), 1'b0, 8'd0);
		end
	endtask

	task automatic set_pacing(input int profile);
		case (profile)
			0: begin tx_idle_pct = 31; rx_stall_pct = 75; end
			1: begin tx_idle_pct = 75; rx_stall_pct = 31; end
			default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
		endcase
	endtask

	// Receiver backpressure, redrawn every cycle.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= rx_stall_pct);

	// Check each output transaction against the oldest expected pixel.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pixel_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("[%0t] unexpected output pixel %0d", $realtime, pixel_out);
			end else if (pixel_q[0] !== pixel_out) begin
				report_mismatch("pixel_out", int'(pixel_q[0]), int'(pixel_out));
				void'(pixel_q.pop_front());
			end else begin
				void'(pixel_q.pop_front());
			end
		end
	end

	// Watchdog: any handshake on either channel, or psel high, resets the count.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d cycles without a transaction, %0d pixels outstanding",
				idle_cycles, pixel_q.size());
			$display("frame_geometric_remap_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int rand_start;
		int phase;
		int phase_end;
		logic [3:0] xf;

		// Directed script: load the corners, the frame center and two more enlarge sources,
		// then read telling pixels under every transform code family.
		script(ST_WR, 8'd0,   8'd0,   8'h00);
		script(ST_WR, 8'd0,   8'd255, 8'hFF);
		script(ST_WR, 8'd255, 8'd0,   8'hA5);
		script(ST_WR, 8'd255, 8'd255, 8'h5A);
		script(ST_WR, 8'd128, 8'd128, 8'h80);
		script(ST_WR, 8'd127, 8'd127, 8'h7F);
		script(ST_WR, 8'd0,   8'd128, 8'h11);
		script(ST_RD, 8'd0,   8'd0,   8'h00);      // shrink by 2 out of reset
		script(ST_RD, 8'd128, 8'd0,   WHITE);      // row product past the last index
		script(ST_RD, 8'd0,   8'd128, WHITE);      // column product past the last index
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_SHRINK4));
		script(ST_RD, 8'd64,  8'd0,   WHITE);
		script(ST_RD, 8'd0,   8'd0,   8'h00);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_SHRINK3));
		script(ST_RD, 8'd85,  8'd85,  8'h5A);      // lands exactly on the last pixel
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_MIR_LEFT));
		script(ST_RD, 8'd255, 8'd255, 8'hA5);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_MIR_RGHT));
		script(ST_RD, 8'd0,   8'd0,   8'hFF);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_MIR_TOP));
		script(ST_RD, 8'd255, 8'd0,   8'h00);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_MIR_BOT));
		script(ST_RD, 8'd0,   8'd255, 8'h5A);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_FLIP_ROW));
		script(ST_RD, 8'd0,   8'd0,   8'hA5);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_FLIP_COL));
		script(ST_RD, 8'd255, 8'd255, 8'hA5);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_ENL_TL));
		script(ST_RD, 8'd255, 8'd255, 8'h7F);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_ENL_TR));
		script(ST_RD, 8'd0,   8'd0,   8'h11);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_ENL_BL));
		script(ST_RD, 8'd254, 8'd1,   8'hA5);
		script(ST_CFG, 8'd0, 8'd0, 8'(TR_ENL_BR));
		script(ST_RD, 8'd0,   8'd0,   8'h80);
		script(ST_CFG, 8'd0, 8'd0, 8'hF);          // unused code: straight pass-through
		script(ST_RD, 8'd0,   8'd255, 8'hFF);

		set_pacing(0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_q[i]) begin
			case (script_q[i].kind)
				ST_CFG: begin
					settle_block();
					write_transform(script_q[i].v[3:0]);
				end
				ST_WR: push_pixel_op(FUNC_WR, script_q[i].r, script_q[i].c, script_q[i].v,
					1'b0, 8'd0);
				default: push_pixel_op(FUNC_RD, script_q[i].r, script_q[i].c,
					$urandom_range(255), 1'b1, script_q[i].v);
			endcase
		end

		// Random phases, one transform setting each. The first sixteen walk every
		// code in order, extremes included; later ones pick codes at random. Each
		// change waits for the block to drain, so the sender also sits idle until
		// every expected pixel is back.
		rand_start = n_items;
		phase = 0;
		while (n_items < rand_start + RAND_ITEMS) begin
			xf = (phase < 16) ? 4'(phase) : 4'($urandom_range(15));
			settle_block();
			write_transform(xf);
			phase_end = n_items + $urandom_range(40, 110);
			while (n_items < phase_end && n_items < rand_start + RAND_ITEMS) begin
				if (n_items - rand_start < RAND_ITEMS / 3)
					set_pacing(0);
				else if (n_items - rand_start < 2 * RAND_ITEMS / 3)
					set_pacing(1);
				else
					set_pacing(2);
				random_step();
			end
			phase++;
		end

		settle_block();
		err_cnt += pixel_q.size();

		$display("Ran %0d pixel transactions and checked %0d output pixels", n_items, n_results);
		$display("across %0d transform settings and three pacing profiles", n_xf_writes);
		if (err_cnt == 0)
			$display("frame_geometric_remap_tb OK");
		else
			$display("frame_geometric_remap_tb NOT OK");
		$finish;
	end

endmodule
